@@ hw/rtl/motor_velocity_watchdog_ramp_assert.svh @@
// assertion macros for the motor velocity watchdog checker
// expects clk and rst_n in the scope where a macro is used
`ifndef MOTOR_VELOCITY_WATCHDOG_RAMP_ASSERT_SVH
`define MOTOR_VELOCITY_WATCHDOG_RAMP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MVWR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define MVWR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/mvwr_pkg.sv @@
// shared types and constants for the motor velocity watchdog ramp block
// no dependencies; imported by every module of the block
package mvwr_pkg;

    // motor count range is 1 to 2 (motor_index is one bit)
    localparam int MOTOR_COUNT_DEFAULT = 2;

    // mode codes
    localparam logic [2:0] MODE_DISABLE   = 3'd0;
    localparam logic [2:0] MODE_POSITION  = 3'd1;
    localparam logic [2:0] MODE_VELOCITY  = 3'd2;
    localparam logic [2:0] MODE_TORQUE    = 3'd3;
    localparam logic [2:0] MODE_DIRECT    = 3'd4;
    localparam logic [2:0] MODE_EMERGENCY = 3'd5;

    // item opcodes
    localparam logic [1:0] OP_VEL_CMD  = 2'd0;
    localparam logic [1:0] OP_TICK     = 2'd1;
    localparam logic [1:0] OP_SET_MODE = 2'd2;
    localparam logic [1:0] OP_NOP      = 2'd3;

    // register indexes on the config port
    localparam int         ADDR_W          = 5;
    localparam logic [2:0] REG_VEL_LIMIT   = 3'd0;
    localparam logic [2:0] REG_TIMEOUT     = 3'd1;
    localparam logic [2:0] REG_RAMP_STEPS  = 3'd2;
    localparam logic [2:0] REG_STOP_TICKS  = 3'd3;
    localparam logic [2:0] REG_POLARITY    = 3'd4;

    // register reset values
    localparam logic [14:0] VEL_LIMIT_RST  = 15'd25000;
    localparam logic [15:0] TIMEOUT_RST    = 16'd500;
    localparam logic [14:0] RAMP_STEPS_RST = 15'd1000;
    localparam logic [15:0] STOP_TICKS_RST = 16'd2000;
    localparam logic [1:0]  POLARITY_RST   = 2'd0;

    // bit-serial divider: one quotient bit per cycle
    localparam int DIV_STEPS = 16;

    typedef struct packed {
        logic [14:0] velocity_limit;
        logic [15:0] timeout_ticks;
        logic [14:0] ramp_steps;
        logic [15:0] stop_ticks;
        logic [1:0]  enable_polarity;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] ref_vel;
        logic [15:0] latched;
        logic [15:0] alive;
        logic [15:0] stop_cnt;
    } motor_state_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        motor_index;
        logic [15:0] velocity_cmd;
        logic [2:0]  new_mode;
    } item_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] reference_velocity;
        logic        enable_out;
        logic        watchdog_tripped;
        logic        ramp_finished;
    } result_t;

endpackage

@@ hw/rtl/mvwr_regs.sv @@
// apb configuration registers of the watchdog ramp block
// depends on mvwr_pkg for register indexes, reset values and cfg_t
module mvwr_regs
    import mvwr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.velocity_limit  <= VEL_LIMIT_RST;
            cfg_reg.timeout_ticks   <= TIMEOUT_RST;
            cfg_reg.ramp_steps      <= RAMP_STEPS_RST;
            cfg_reg.stop_ticks      <= STOP_TICKS_RST;
            cfg_reg.enable_polarity <= POLARITY_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_VEL_LIMIT:  cfg_reg.velocity_limit  <= pwdata[14:0];
                REG_TIMEOUT:    cfg_reg.timeout_ticks   <= pwdata[15:0];
                REG_RAMP_STEPS: cfg_reg.ramp_steps      <= pwdata[14:0];
                REG_STOP_TICKS: cfg_reg.stop_ticks      <= pwdata[15:0];
                REG_POLARITY:   cfg_reg.enable_polarity <= pwdata[1:0];
                default:        ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        unique case (reg_idx)
            REG_VEL_LIMIT:  prdata = {17'd0, cfg_reg.velocity_limit};
            REG_TIMEOUT:    prdata = {16'd0, cfg_reg.timeout_ticks};
            REG_RAMP_STEPS: prdata = {17'd0, cfg_reg.ramp_steps};
            REG_STOP_TICKS: prdata = {16'd0, cfg_reg.stop_ticks};
            REG_POLARITY:   prdata = {30'd0, cfg_reg.enable_polarity};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

@@ hw/rtl/mvwr_serial_div.sv @@
// bit-serial restoring divider for the emergency ramp step
// depends on mvwr_pkg for DIV_STEPS; one quotient bit per cycle
module mvwr_serial_div
    import mvwr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [14:0] divisor,
    output logic        done,
    output logic [15:0] quotient
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [14:0]      rem_reg;
    logic [15:0]      quo_reg;
    logic [14:0]      dvs_reg;
    logic [15:0]      shifted;
    logic [15:0]      diff;
    logic             fits;

    // one restoring step: bring down the next dividend bit
    assign shifted = {rem_reg, quo_reg[15]};
    assign fits    = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    assign done     = done_reg;
    assign quotient = quo_reg;

    // step control
    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
        end
        else if (busy_reg)
        begin
            count_next = count_reg + 1'b1;
            if (count_reg == CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // remainder and quotient shift registers; a zero divisor acts as one
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= (divisor == '0) ? 15'd1 : divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[14:0] : shifted[14:0];
            quo_reg <= {quo_reg[14:0], fits};
        end
    end

endmodule

@@ hw/rtl/mvwr_update.sv @@
// per-item state update and result of one motor
// depends on mvwr_pkg for item, state, config and result types
module mvwr_update
    import mvwr_pkg::*;
(
    input  item_t        item,
    input  logic         in_range,
    input  motor_state_t cur,
    input  cfg_t         cfg,
    input  logic [16:0]  ramp_step,
    output motor_state_t nxt,
    output result_t      res
);

    localparam logic signed [17:0] SAT_HI = 18'sd32767;
    localparam logic signed [17:0] SAT_LO = -18'sd32768;

    logic signed [16:0] cmd_x;
    logic signed [16:0] lim_x;
    logic signed [16:0] neg_lim_x;
    logic [15:0]        cmd_clamped;
    logic signed [17:0] r_raw;
    logic signed [17:0] r_fix;
    logic [15:0]        r_sat;
    logic               lat_neg;
    logic               lat_pos;
    logic               r_neg;
    logic               r_pos;
    logic [16:0]        stop_inc;
    logic [16:0]        alive_inc;
    logic               pol;
    logic               tripped;
    logic               finished;

    // command clamp to the velocity limit
    assign cmd_x     = {item.velocity_cmd[15], item.velocity_cmd};
    assign lim_x     = {2'b00, cfg.velocity_limit};
    assign neg_lim_x = -lim_x;
    assign cmd_clamped = (cmd_x > lim_x)     ? lim_x[15:0] :
                         (cmd_x < neg_lim_x) ? neg_lim_x[15:0] :
                                               item.velocity_cmd;

    // emergency ramp: step toward zero, zero on sign flip, saturate
    assign r_raw   = $signed({{2{cur.ref_vel[15]}}, cur.ref_vel})
                   - $signed({ramp_step[16], ramp_step});
    assign lat_neg = cur.latched[15];
    assign lat_pos = !cur.latched[15] && (cur.latched != '0);
    assign r_neg   = r_raw[17];
    assign r_pos   = !r_raw[17] && (r_raw != '0);
    assign r_fix   = ((r_pos && lat_neg) || (r_neg && lat_pos)) ? '0 : r_raw;
    assign r_sat   = (r_fix > SAT_HI) ? SAT_HI[15:0] :
                     (r_fix < SAT_LO) ? SAT_LO[15:0] : r_fix[15:0];

    assign stop_inc  = {1'b0, cur.stop_cnt} + 17'd1;
    assign alive_inc = {1'b0, cur.alive} + 17'd1;
    assign pol       = cfg.enable_polarity[item.motor_index];

    // state transition by opcode and mode
    always_comb
    begin
        nxt      = cur;
        tripped  = 1'b0;
        finished = 1'b0;
        unique case (item.opcode)
            OP_VEL_CMD:
            begin
                nxt.alive   = '0;
                nxt.mode    = MODE_VELOCITY;
                nxt.ref_vel = cmd_clamped;
            end
            OP_SET_MODE:
            begin
                if (item.new_mode <= MODE_EMERGENCY)
                begin
                    nxt.mode = item.new_mode;
                    if (item.new_mode == MODE_EMERGENCY)
                    begin
                        nxt.latched = cur.ref_vel;
                    end
                end
            end
            OP_TICK:
            begin
                if (cur.mode == MODE_EMERGENCY)
                begin
                    nxt.ref_vel = r_sat;
                    if (r_sat == '0)
                    begin
                        if (stop_inc >= {1'b0, cfg.stop_ticks})
                        begin
                            nxt.mode     = MODE_DISABLE;
                            nxt.stop_cnt = '0;
                            finished     = 1'b1;
                        end
                        else
                        begin
                            nxt.stop_cnt = stop_inc[15:0];
                        end
                    end
                end
                else if (cur.mode == MODE_DISABLE)
                begin
                    nxt.ref_vel = '0;
                end
                // watchdog runs only in the active modes
                if (cur.mode >= MODE_POSITION && cur.mode <= MODE_DIRECT)
                begin
                    if (alive_inc >= {1'b0, cfg.timeout_ticks})
                    begin
                        nxt.mode     = MODE_EMERGENCY;
                        nxt.latched  = cur.ref_vel;
                        nxt.stop_cnt = '0;
                        nxt.alive    = '0;
                        tripped      = 1'b1;
                    end
                    else
                    begin
                        nxt.alive = alive_inc[15:0];
                    end
                end
            end
            OP_NOP:
            begin
            end
        endcase
    end

    // result; an unknown motor reports all zeros
    always_comb
    begin
        if (in_range)
        begin
            res.mode               = nxt.mode;
            res.reference_velocity = nxt.ref_vel;
            res.enable_out         = (nxt.mode != MODE_DISABLE) ^ pol;
            res.watchdog_tripped   = tripped;
            res.ramp_finished      = finished;
        end
        else
        begin
            res = '0;
        end
    end

endmodule

@@ hw/rtl/motor_velocity_watchdog_ramp.sv @@
// Motor command watchdog with emergency ramp-down. An accepted item goes to S_APPLY,
// where its result enters the output register once that register is free; a tick to
// a motor in emergency goes through S_DIV first, as the ramp step latched/ramp_steps
// comes from a bit-serial restoring divider that produces one quotient bit per cycle.
// One item is in work at a time; the next is accepted as soon as the previous result
// is in the output register, even while that result waits.
// Depends on mvwr_pkg, mvwr_regs, mvwr_serial_div and mvwr_update.
module motor_velocity_watchdog_ramp
    import mvwr_pkg::*;
#(
    parameter int MOTOR_COUNT = MOTOR_COUNT_DEFAULT
)
(
    input  logic              clk,
    input  logic              rst_n,
    // config port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // item input
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        opcode,
    input  logic              motor_index,
    input  logic [15:0]       velocity_cmd,
    input  logic [2:0]        new_mode,
    // result output
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        mode,
    output logic [15:0]       reference_velocity,
    output logic              enable_out,
    output logic              watchdog_tripped,
    output logic              ramp_finished
);

    localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_DIV   = 3'b010,
        S_APPLY = 3'b100
    } fsm_t;

    fsm_t         fsm_reg, fsm_next;
    motor_state_t motor_reg [MOTOR_COUNT];
    item_t        item_reg;
    logic         in_range_reg;
    logic         out_valid_reg, out_valid_next;
    result_t      res_reg;

    cfg_t         cfg;
    logic         accept;
    logic         in_range_in;
    logic [IDX_W-1:0] in_idx;
    logic [IDX_W-1:0] cur_idx;
    motor_state_t cur_in;
    motor_state_t cur;
    motor_state_t nxt;
    result_t      res;
    logic         need_div;
    logic [15:0]  lat_mag;
    logic         div_done;
    logic [15:0]  div_quotient;
    logic [16:0]  ramp_mag;
    logic [16:0]  ramp_step;
    logic         out_free;
    logic         apply_fire;

    assign pready = 1'b1;

    mvwr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // handshake and motor lookup on the incoming item
    assign in_ready    = (fsm_reg == S_IDLE);
    assign accept      = in_valid && in_ready;
    assign in_range_in = ({31'd0, motor_index} < MOTOR_COUNT);
    assign in_idx      = IDX_W'(motor_index);
    assign cur_in      = motor_reg[in_idx];
    assign need_div    = (opcode == OP_TICK) && in_range_in
                      && (cur_in.mode == MODE_EMERGENCY);
    assign lat_mag     = cur_in.latched[15] ? (~cur_in.latched + 16'd1) : cur_in.latched;

    mvwr_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && need_div),
        .dividend (lat_mag),
        .divisor  (cfg.ramp_steps),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // signed ramp step from the quotient magnitude and latched sign
    assign cur_idx   = IDX_W'(item_reg.motor_index);
    assign cur       = motor_reg[cur_idx];
    assign ramp_mag  = {1'b0, div_quotient};
    assign ramp_step = cur.latched[15] ? (~ramp_mag + 17'd1) : ramp_mag;

    mvwr_update u_update (
        .item      (item_reg),
        .in_range  (in_range_reg),
        .cur       (cur),
        .cfg       (cfg),
        .ramp_step (ramp_step),
        .nxt       (nxt),
        .res       (res)
    );

    assign out_free   = !out_valid_reg || out_ready;
    assign apply_fire = (fsm_reg == S_APPLY) && out_free;

    // sequencer
    always_comb
    begin
        fsm_next = fsm_reg;
        unique case (fsm_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    fsm_next = need_div ? S_DIV : S_APPLY;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    fsm_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (out_free)
                begin
                    fsm_next = S_IDLE;
                end
            end
            default: fsm_next = S_IDLE;
        endcase
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (apply_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg       <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fsm_reg       <= fsm_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // per-motor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MOTOR_COUNT; i++)
            begin
                motor_reg[i] <= '0;
            end
        end
        else if (apply_fire && in_range_reg)
        begin
            motor_reg[cur_idx] <= nxt;
        end
    end

    // item capture and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.opcode       <= opcode;
            item_reg.motor_index  <= motor_index;
            item_reg.velocity_cmd <= velocity_cmd;
            item_reg.new_mode     <= new_mode;
            in_range_reg          <= in_range_in;
        end
        if (apply_fire)
        begin
            res_reg <= res;
        end
    end

    assign out_valid          = out_valid_reg;
    assign mode               = res_reg.mode;
    assign reference_velocity = res_reg.reference_velocity;
    assign enable_out         = res_reg.enable_out;
    assign watchdog_tripped   = res_reg.watchdog_tripped;
    assign ramp_finished      = res_reg.ramp_finished;

endmodule

@@ hw/rtl/mvwr_checker.sv @@
// port-level checks for the motor velocity watchdog ramp block
// depends on mvwr_pkg and the assertion macro header; bound to the top level
`include "motor_velocity_watchdog_ramp_assert.svh"

module mvwr_checker
    import mvwr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  mode,
    input logic [15:0] reference_velocity,
    input logic        enable_out,
    input logic        watchdog_tripped,
    input logic        ramp_finished
);

    // a stalled result item holds
    `MVWR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(mode) && $stable(reference_velocity) && $stable(enable_out) && $stable(watchdog_tripped) && $stable(ramp_finished), "stalled result item changed")

    // one item in work at a time
    `MVWR_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "item accepted while previous item in work")

    // a trip always reports emergency
    `MVWR_ASSERT_NOW(a_trip_mode, out_valid && watchdog_tripped, mode == MODE_EMERGENCY, "watchdog trip without emergency mode")

    // end of ramp leaves the motor disabled at zero
    `MVWR_ASSERT_NOW(a_finish_state, out_valid && ramp_finished, mode == MODE_DISABLE && reference_velocity == 16'd0, "ramp finished without disabled motor at zero")

endmodule

bind motor_velocity_watchdog_ramp mvwr_checker u_mvwr_checker (.*);
